>>> src/bf16_vector_sum_reducer_assert.svh
// Assertion macros for the reducer's top-level RTL file.
// Each macro expects clk and arst_n in scope.
`ifndef BF16_VECTOR_SUM_REDUCER_ASSERT_SVH
`define BF16_VECTOR_SUM_REDUCER_ASSERT_SVH

// Same-cycle implication.
`define BVSR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BVSR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/bvsr_pkg.sv
package bvsr_pkg;

	// Geometry of the accumulator store; both counts are powers of two.
	localparam int VECTOR_LEN = 4096;
	localparam int SLOT_COUNT = 4;
	localparam int MAX_RANKS  = 16;

	localparam int IDX_W  = $clog2(VECTOR_LEN);
	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int ADDR_W = IDX_W + SLOT_W;
	localparam int DEPTH  = SLOT_COUNT * VECTOR_LEN;

	// The arrival mask is 16 bits wide, so a group never exceeds 16 ranks.
	localparam int MASK_W    = 16;
	localparam int GROUP_MAX = (MAX_RANKS < MASK_W) ? MAX_RANKS : MASK_W;

	// Item modes; the reserved code changes nothing.
	localparam logic [1:0] MODE_SEED = 2'd0;
	localparam logic [1:0] MODE_FOLD = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;
	localparam logic [1:0] MODE_RSVD = 2'd3;

	// Configuration register indexes.
	localparam logic [3:0] CFG_PEER_COUNT = 4'd0;
	localparam logic [3:0] CFG_OWN_RANK   = 4'd1;

	localparam logic [31:0] ROUND_BIAS = 32'h0000_7fff;
	localparam logic [31:0] QNAN_BIT   = 32'h0040_0000;
	localparam logic [31:0] DEFAULT_NAN = 32'hffc0_0000;
	localparam logic [30:0] INF_ABS    = 31'h7f80_0000;

	// Decision made by the arrival tracker for one item.
	typedef struct packed {
		logic ign;
		logic all_arrived;
		logic do_write;
	} bvsr_arr_t;

	// Result fields of one item.
	typedef struct packed {
		logic [15:0] sum_value;
		logic        all_arrived;
		logic        ignored;
	} bvsr_res_t;

	// Item as it enters the datapath.
	typedef struct packed {
		logic [1:0]        mode;
		logic [ADDR_W-1:0] addr;
		logic [15:0]       value;
		bvsr_arr_t         arr;
	} bvsr_item_t;

	// Fields that ride along with the arithmetic.
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              do_write;
		logic              spec;
		logic [31:0]       spec_val;
		bvsr_res_t         res;
	} bvsr_tag_t;

	// Leading zeros of a 27-bit mantissa, counted from bit 26.
	function automatic logic [4:0] lzc27(input logic [26:0] m);
		logic [4:0] n;
		logic       found;
		n     = 5'd27;
		found = 1'b0;
		for (int i = 26; i >= 0; i--) begin
			if (!found && m[i]) begin
				n     = 5'(26 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

endpackage

>>> src/bvsr_if.sv
// Input item channel.
interface bvsr_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [1:0]  slot;
	logic [11:0] elem_index;
	logic [3:0]  source_rank;
	logic [15:0] value;
	logic        last_of_vector;

	modport source(output valid, mode, slot, elem_index, source_rank, value, last_of_vector,
		input ready);
	modport sink(input valid, mode, slot, elem_index, source_rank, value, last_of_vector,
		output ready);
endinterface

// Result item channel.
interface bvsr_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] sum_value;
	logic        all_arrived;
	logic        ignored;

	modport source(output valid, sum_value, all_arrived, ignored, input ready);
	modport sink(input valid, sum_value, all_arrived, ignored, output ready);
endinterface

// Configuration write channel.
interface bvsr_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] index;
	logic [4:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> src/bvsr_ram.sv
module bvsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/bvsr_arrival.sv
module bvsr_arrival import bvsr_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [3:0]      cfg_index,
	input  logic [4:0]      cfg_data,
	input  logic            accept,
	input  logic [1:0]      mode,
	input  logic [1:0]      slot,
	input  logic [3:0]      source_rank,
	input  logic            last_of_vector,
	output bvsr_arr_t       arr
);

	logic [4:0]        peer_count_q;
	logic [3:0]        own_rank_q;
	logic [MASK_W-1:0] mask_q [SLOT_COUNT];

	logic [4:0]        n;
	logic [MASK_W:0]   want_wide;
	logic [MASK_W-1:0] want;
	logic [MASK_W-1:0] cur;
	logic [MASK_W-1:0] nxt;
	logic [SLOT_W-1:0] sel;

	// Group size after clamping, and the mask of a complete group.
	always_comb begin
		n = peer_count_q;
		if (n == 5'd0) begin
			n = 5'd1;
		end
		if (n > 5'(GROUP_MAX)) begin
			n = 5'(GROUP_MAX);
		end
		want_wide = (MASK_W+1)'(1) << n;
		want_wide = want_wide - (MASK_W+1)'(1);
		want      = want_wide[MASK_W-1:0];
	end

	// Per-item decision and next mask of the addressed slot.
	always_comb begin
		sel = slot[SLOT_W-1:0];
		cur = mask_q[sel];
		nxt = cur;
		arr = '0;
		case (mode)
			MODE_SEED: begin
				nxt          = MASK_W'(1) << own_rank_q;
				arr.do_write = 1'b1;
			end
			MODE_FOLD: begin
				if ({1'b0, source_rank} >= n || cur[source_rank]) begin
					arr.ign = 1'b1;
				end else begin
					arr.do_write = 1'b1;
					if (last_of_vector) begin
						nxt = cur | (MASK_W'(1) << source_rank);
					end
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
		arr.all_arrived = (nxt == want);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peer_count_q <= 5'd16;
			own_rank_q   <= 4'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PEER_COUNT: peer_count_q <= cfg_data;
				CFG_OWN_RANK:   own_rank_q   <= cfg_data[3:0];
				default:        peer_count_q <= peer_count_q;
			endcase
		end
	end

	// Arrival masks update as items are accepted, in order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				mask_q[i] <= '0;
			end
		end else if (accept) begin
			mask_q[sel] <= nxt;
		end
	end

endmodule

>>> src/bvsr_fpipe.sv
module bvsr_fpipe import bvsr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              load,
	input  bvsr_item_t        item,
	input  logic [31:0]       rdata,
	input  logic [ADDR_W-1:0] chk_addr,
	output logic              hazard,
	output logic              v_s4_o,
	output logic              wr_req,
	output logic [ADDR_W-1:0] wr_addr,
	output logic [31:0]       wr_data,
	output bvsr_res_t         res
);

	// Stage 1: item plus the accumulator word read at accept.
	logic       v_s1;
	bvsr_item_t it_s1;

	// Stage 2: aligned operands.
	logic        v_s2;
	bvsr_tag_t   tag_s2;
	logic        sa_s2, sub_s2;
	logic [7:0]  e_s2;
	logic [26:0] ma_s2, mb_s2;

	// Stage 3: raw sum.
	logic        v_s3;
	bvsr_tag_t   tag_s3;
	logic        sa_s3, zero_s3;
	logic [8:0]  e_s3;
	logic [26:0] m_s3;

	// Stage 4: normalized sum.
	logic        v_s4;
	bvsr_tag_t   tag_s4;
	logic        sa_s4, zero_s4;
	logic [8:0]  e_s4;
	logic [26:0] m_s4;

	// Stage 1 logic: special cases, read rounding, swap and alignment.
	logic [31:0] a, b, x, y, u;
	logic [30:0] aabs, babs;
	logic        a_nan, b_nan, a_inf, b_inf;
	bvsr_tag_t   tag1;
	logic [7:0]  ex, ey, d;
	logic [26:0] mx, my, sh, mb_al;

	always_comb begin
		a    = rdata;
		b    = {it_s1.value, 16'h0000};
		aabs = a[30:0];
		babs = b[30:0];
		a_nan = aabs > INF_ABS;
		b_nan = babs > INF_ABS;
		a_inf = aabs == INF_ABS;
		b_inf = babs == INF_ABS;

		tag1.addr     = it_s1.addr;
		tag1.do_write = it_s1.arr.do_write;
		tag1.spec     = 1'b1;
		tag1.spec_val = b;
		if (it_s1.mode == MODE_SEED) begin
			tag1.spec_val = b;
		end else if (a_nan) begin
			tag1.spec_val = a | QNAN_BIT;
		end else if (b_nan) begin
			tag1.spec_val = b | QNAN_BIT;
		end else if (a_inf) begin
			tag1.spec_val = (b_inf && (a[31] != b[31])) ? DEFAULT_NAN : a;
		end else if (b_inf) begin
			tag1.spec_val = b;
		end else begin
			tag1.spec = 1'b0;
		end

		// Read mode rounds the accumulator to bf16 without NaN care.
		u = a + ROUND_BIAS + {31'b0, a[16]};
		tag1.res.sum_value   = (it_s1.mode == MODE_READ) ? u[31:16] : 16'h0000;
		tag1.res.all_arrived = it_s1.arr.all_arrived;
		tag1.res.ignored     = it_s1.arr.ign;

		// Larger magnitude first; subnormals take exponent one.
		x  = (babs > aabs) ? b : a;
		y  = (babs > aabs) ? a : b;
		ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
		ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
		mx = {(x[30:23] != 8'd0), x[22:0], 3'b000};
		my = {(y[30:23] != 8'd0), y[22:0], 3'b000};
		d  = ex - ey;
		sh = my >> d[4:0];
		if (d > 8'd26) begin
			mb_al = {26'b0, (my != 27'd0)};
		end else begin
			mb_al = sh | {26'b0, ((sh << d[4:0]) != my)};
		end
	end

	// Stage 2 logic: add or subtract the aligned mantissas.
	logic [27:0] sum28;
	logic [26:0] m2;
	logic [8:0]  e2;
	logic        zero2;

	always_comb begin
		sum28 = {1'b0, ma_s2} + {1'b0, mb_s2};
		e2    = {1'b0, e_s2};
		zero2 = 1'b0;
		if (sub_s2) begin
			m2    = ma_s2 - mb_s2;
			zero2 = (m2 == 27'd0);
		end else if (sum28[27]) begin
			m2 = sum28[27:1] | {26'b0, sum28[0]};
			e2 = e2 + 9'd1;
		end else begin
			m2 = sum28[26:0];
		end
	end

	// Stage 3 logic: normalize, keeping the exponent at one or above.
	logic [4:0]  lz;
	logic [8:0]  lim, nsh;
	logic [26:0] m3;
	logic [8:0]  e3;

	always_comb begin
		lz  = lzc27(m_s3);
		lim = e_s3 - 9'd1;
		nsh = ({4'b0, lz} < lim) ? {4'b0, lz} : lim;
		m3  = m_s3 << nsh[4:0];
		e3  = e_s3 - nsh;
	end

	// Stage 4 logic: round to nearest even and pack.
	logic [2:0]  rb;
	logic        up;
	logic [24:0] mr;
	logic [23:0] mf;
	logic [8:0]  ef, em1;
	logic [31:0] packed_val, fold_val;

	always_comb begin
		rb = m_s4[2:0];
		up = (rb > 3'd4) || ((rb == 3'd4) && m_s4[3]);
		mr = {1'b0, m_s4[26:3]} + {24'b0, up};
		ef = e_s4;
		mf = mr[23:0];
		if (mr[24]) begin
			mf = mr[24:1];
			ef = e_s4 + 9'd1;
		end
		em1        = ef - 9'd1;
		packed_val = {sa_s4, 31'b0} + {1'b0, em1[7:0], 23'b0} + {8'b0, mf};
		if (tag_s4.spec) begin
			fold_val = tag_s4.spec_val;
		end else if (zero_s4) begin
			fold_val = 32'h0;
		end else if ((em1 + {8'b0, mf[23]}) >= 9'd255) begin
			fold_val = {sa_s4, 8'hff, 23'b0};
		end else begin
			fold_val = packed_val;
		end
	end

	assign wr_req  = v_s4 && tag_s4.do_write;
	assign wr_addr = tag_s4.addr;
	assign wr_data = fold_val;
	assign res     = tag_s4.res;
	assign v_s4_o  = v_s4;

	// Any stage still owing a write to the address blocks a new read of it.
	assign hazard = (v_s1 && it_s1.arr.do_write && it_s1.addr == chk_addr)
		|| (v_s2 && tag_s2.do_write && tag_s2.addr == chk_addr)
		|| (v_s3 && tag_s3.do_write && tag_s3.addr == chk_addr)
		|| (v_s4 && tag_s4.do_write && tag_s4.addr == chk_addr);

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= load;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en) begin
			it_s1   <= item;
			tag_s2  <= tag1;
			sa_s2   <= x[31];
			sub_s2  <= x[31] != y[31];
			e_s2    <= ex;
			ma_s2   <= mx;
			mb_s2   <= mb_al;
			tag_s3  <= tag_s2;
			sa_s3   <= sa_s2;
			zero_s3 <= zero2;
			e_s3    <= e2;
			m_s3    <= m2;
			tag_s4  <= tag_s3;
			sa_s4   <= sa_s3;
			zero_s4 <= zero_s3;
			e_s4    <= e3;
			m_s4    <= m3;
		end
	end

endmodule

>>> src/bf16_vector_sum_reducer.sv
// Channel  Role   Payload
// din      sink   mode, slot, elem_index, source_rank, value, last_of_vector
// dout     source sum_value, all_arrived, ignored
// cfg      sink   index, data (0 peer_count, 1 own_rank)
//
// One item per cycle unless a stall or a read hazard holds the input; results
// pass the adder pipeline and the result register. An item that reads an
// accumulator word still being written by an earlier item waits for that write.
// Reset clears the arrival masks and restores peer_count 16, own_rank 0.
// A stalled result register freezes the whole pipeline; nothing is dropped.
`include "bf16_vector_sum_reducer_assert.svh"

module bf16_vector_sum_reducer import bvsr_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	bvsr_in_if.sink      din,
	bvsr_out_if.source   dout,
	bvsr_cfg_if.sink     cfg
);

	logic              en;
	logic              accept;
	logic              need_read;
	logic              hazard;
	logic [ADDR_W-1:0] addr;
	bvsr_arr_t         arr;
	bvsr_item_t        item;
	logic [31:0]       rdata;
	logic              v_s4;
	logic              wr_req;
	logic              ram_we;
	logic [ADDR_W-1:0] wr_addr;
	logic [31:0]       wr_data;
	bvsr_res_t         res;
	logic              out_valid_q;
	bvsr_res_t         out_q;

	// Pipeline advances whenever the result register can take a new item.
	assign en        = !out_valid_q || dout.ready;
	assign need_read = (din.mode == MODE_FOLD) || (din.mode == MODE_READ);
	assign addr      = {din.slot[SLOT_W-1:0], din.elem_index[IDX_W-1:0]};
	assign din.ready = en && !(need_read && hazard);
	assign accept    = din.valid && din.ready;
	assign cfg.ready = 1'b1;
	assign ram_we    = en && wr_req;

	bvsr_arrival u_arrival (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.accept         (accept),
		.mode           (din.mode),
		.slot           (din.slot),
		.source_rank    (din.source_rank),
		.last_of_vector (din.last_of_vector),
		.arr            (arr)
	);

	assign item.mode  = din.mode;
	assign item.addr  = addr;
	assign item.value = din.value;
	assign item.arr   = arr;

	bvsr_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_acc (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (accept),
		.raddr (addr),
		.rdata (rdata)
	);

	bvsr_fpipe u_fpipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.load     (accept),
		.item     (item),
		.rdata    (rdata),
		.chk_addr (addr),
		.hazard   (hazard),
		.v_s4_o   (v_s4),
		.wr_req   (wr_req),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.res      (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= res;
		end
	end

	assign dout.valid       = out_valid_q;
	assign dout.sum_value   = out_q.sum_value;
	assign dout.all_arrived = out_q.all_arrived;
	assign dout.ignored     = out_q.ignored;

	// A reading item never fetches a word whose write retires in the same cycle.
	`BVSR_ASSERT_IMP(a_no_raw, ram_we && accept && need_read, wr_addr != addr, "read hit pending write")
	// A held pipeline keeps its last stage.
	`BVSR_ASSERT_NXT(a_stall_hold, !en, v_s4 == $past(v_s4), "last stage moved during stall")
	// A finished item reaches the result register.
	`BVSR_ASSERT_NXT(a_to_out, en && v_s4, out_valid_q, "result lost")

endmodule
